// ===== rtl/core/wuf_pkg.sv =====
`default_nettype none
package wuf_pkg;

    localparam int NODE_W = 10;
    localparam int POT_W  = 64;
    localparam int OFF_W  = 32;

    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [NODE_W-1:0]       node_a;
        logic [NODE_W-1:0]       node_b;
        logic signed [OFF_W-1:0] offset;
    } in_beat_t;

    typedef struct packed {
        logic                    known;
        logic signed [POT_W-1:0] difference;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UP_RD,
        ST_UP_CHK,
        ST_DN_RD,
        ST_DN_PRD,
        ST_DN_WR,
        ST_FIN_A,
        ST_POT_A,
        ST_POT_B,
        ST_LINK,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/wuf_store.sv =====
`default_nettype none
module wuf_store #(
    parameter int NODES = 1024,
    parameter int AW    = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      par_we,
    input  wire logic [AW-1:0]             par_waddr,
    input  wire logic [AW-1:0]             par_wdata,
    input  wire logic [AW-1:0]             par_raddr,
    output logic      [AW-1:0]             par_rdata,
    input  wire logic                      pot_we,
    input  wire logic [AW-1:0]             pot_waddr,
    input  wire logic [wuf_pkg::POT_W-1:0] pot_wdata,
    input  wire logic [AW-1:0]             pot_raddr,
    output logic      [wuf_pkg::POT_W-1:0] pot_rdata
);

    logic [AW-1:0]             par_mem [NODES];
    logic [wuf_pkg::POT_W-1:0] pot_mem [NODES];

    always_ff @(posedge aclk) begin
        if (par_we) begin
            par_mem[par_waddr] <= par_wdata;
        end
        par_rdata <= par_mem[par_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pot_we) begin
            pot_mem[pot_waddr] <= pot_wdata;
        end
        pot_rdata <= pot_mem[pot_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/wuf_stack.sv =====
`default_nettype none
module wuf_stack #(
    parameter int NODES = 1024,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [AW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [AW-1:0] rdata
);

    logic [AW-1:0] mem [NODES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/weighted_union_find_top.sv =====
// Weighted disjoint-set store with path compression.
// s_ channel takes one beat per item: op, node_a, node_b, offset.
// A merge links root(a) under root(b) with potential pot(b)-pot(a)+offset
// and returns nothing. A query returns one m_ beat: known and pot(a)-pot(b).
// Items run one at a time. Each find walks the links up to the root and
// compresses them on the way down, all through the one read port of the
// parent and potential memories. After reset the block sweeps the parent
// and potential memories, one entry a cycle, with s_ready low; then every
// node is its own root with zero potential.
// A query result waits in the output register until m_ready; the next item
// is taken only after that beat leaves.
`default_nettype none
module weighted_union_find_top #(
    parameter int NODES = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire wuf_pkg::in_beat_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output wuf_pkg::out_beat_t      m_data
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NW = wuf_pkg::NODE_W;
    localparam int PW = wuf_pkg::POT_W;
    localparam int DW = AW + 1;

    wuf_pkg::state_t state_reg, state_next;
    wuf_pkg::in_beat_t item_reg, item_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [AW-1:0] x_reg, x_next;
    logic [PW-1:0] xpot_reg, xpot_next;
    logic          second_reg, second_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic [PW-1:0] pa_reg, pa_next;
    logic [DW-1:0] clr_reg, clr_next;
    logic          mv_reg, mv_next;
    wuf_pkg::out_beat_t mo_reg, mo_next;

    logic          par_we, pot_we, stk_we;
    logic [AW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic [AW-1:0] pot_waddr, pot_raddr;
    logic [PW-1:0] pot_wdata, pot_rdata;
    logic [AW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic          in_range;
    logic [AW-1:0] a_idx, b_idx;

    wuf_store #(.NODES(NODES), .AW(AW)) u_store (
        .aclk, .par_we, .par_waddr, .par_wdata, .par_raddr, .par_rdata,
        .pot_we, .pot_waddr, .pot_wdata, .pot_raddr, .pot_rdata
    );

    wuf_stack #(.NODES(NODES), .AW(AW)) u_stack (
        .aclk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign in_range = ({{(32-NW){1'b0}}, item_reg.node_a} < 32'(NODES)) &&
                      ({{(32-NW){1'b0}}, item_reg.node_b} < 32'(NODES));
    assign a_idx = AW'(item_reg.node_a);
    assign b_idx = AW'(item_reg.node_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wuf_pkg::ST_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        depth_reg  <= depth_next;
        x_reg      <= x_next;
        xpot_reg   <= xpot_next;
        second_reg <= second_next;
        ra_reg     <= ra_next;
        pa_reg     <= pa_next;
        mo_reg     <= mo_next;
    end

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        cur_next    = cur_reg;
        depth_next  = depth_reg;
        x_next      = x_reg;
        xpot_next   = xpot_reg;
        second_next = second_reg;
        ra_next     = ra_reg;
        pa_next     = pa_reg;
        clr_next    = clr_reg;
        mv_next     = mv_reg;
        mo_next     = mo_reg;
        s_ready     = 1'b0;
        par_we      = 1'b0;
        par_waddr   = cur_reg;
        par_wdata   = cur_reg;
        par_raddr   = cur_reg;
        pot_we      = 1'b0;
        pot_waddr   = x_reg;
        pot_wdata   = '0;
        pot_raddr   = cur_reg;
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[AW-1:0];
        stk_wdata   = cur_reg;
        stk_raddr   = depth_reg[AW-1:0];

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            wuf_pkg::ST_CLEAR: begin
                par_we    = 1'b1;
                pot_we    = 1'b1;
                par_waddr = clr_reg[AW-1:0];
                par_wdata = clr_reg[AW-1:0];
                pot_waddr = clr_reg[AW-1:0];
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == DW'(NODES - 1)) begin
                    state_next = wuf_pkg::ST_IDLE;
                end
            end
            wuf_pkg::ST_IDLE: begin
                s_ready = !mv_reg;
                if (s_valid && !mv_reg) begin
                    item_next = s_data;
                    state_next = wuf_pkg::ST_FIN_A;
                end
            end
            wuf_pkg::ST_FIN_A: begin
                second_next = 1'b0;
                cur_next    = a_idx;
                depth_next  = '0;
                if (in_range) begin
                    state_next = wuf_pkg::ST_UP_RD;
                end else if (item_reg.op == wuf_pkg::OP_QUERY) begin
                    mo_next    = '0;
                    state_next = wuf_pkg::ST_OUT;
                end else begin
                    state_next = wuf_pkg::ST_IDLE;
                end
            end
            wuf_pkg::ST_UP_RD: begin
                par_raddr  = cur_reg;
                state_next = wuf_pkg::ST_UP_CHK;
            end
            wuf_pkg::ST_UP_CHK: begin
                if (par_rdata == cur_reg || depth_reg == DW'(NODES)) begin
                    state_next = wuf_pkg::ST_DN_RD;
                end else begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    cur_next   = par_rdata;
                    state_next = wuf_pkg::ST_UP_RD;
                end
            end
            wuf_pkg::ST_DN_RD: begin
                if (depth_reg == '0) begin
                    if (!second_reg) begin
                        ra_next     = cur_reg;
                        second_next = 1'b1;
                        cur_next    = b_idx;
                        state_next  = wuf_pkg::ST_UP_RD;
                    end else if (ra_reg == cur_reg) begin
                        if (item_reg.op == wuf_pkg::OP_QUERY) begin
                            state_next = wuf_pkg::ST_POT_A;
                        end else begin
                            state_next = wuf_pkg::ST_IDLE;
                        end
                    end else if (item_reg.op == wuf_pkg::OP_QUERY) begin
                        mo_next    = '0;
                        state_next = wuf_pkg::ST_OUT;
                    end else begin
                        state_next = wuf_pkg::ST_POT_A;
                    end
                end else begin
                    stk_raddr  = AW'(depth_reg - 1'b1);
                    depth_next = depth_reg - 1'b1;
                    state_next = wuf_pkg::ST_DN_PRD;
                end
            end
            wuf_pkg::ST_DN_PRD: begin
                x_next     = stk_rdata;
                par_raddr  = stk_rdata;
                pot_raddr  = stk_rdata;
                state_next = wuf_pkg::ST_DN_WR;
            end
            wuf_pkg::ST_DN_WR: begin
                xpot_next  = pot_rdata;
                pot_raddr  = par_rdata;
                state_next = wuf_pkg::ST_LINK;
                second_next = second_reg;
            end
            wuf_pkg::ST_LINK: begin
                if (state_reg == wuf_pkg::ST_LINK && depth_reg != DW'(NODES + 1)) begin
                    par_we     = 1'b1;
                    par_waddr  = x_reg;
                    par_wdata  = cur_reg;
                    pot_we     = 1'b1;
                    pot_waddr  = x_reg;
                    pot_wdata  = xpot_reg + pot_rdata;
                    state_next = wuf_pkg::ST_DN_RD;
                end
            end
            wuf_pkg::ST_POT_A: begin
                pot_raddr  = a_idx;
                depth_next = DW'(NODES + 1);
                state_next = wuf_pkg::ST_POT_B;
            end
            wuf_pkg::ST_POT_B: begin
                pot_raddr = b_idx;
                pa_next   = pot_rdata;
                state_next = wuf_pkg::ST_OUT;
                cur_next  = cur_reg;
            end
            wuf_pkg::ST_OUT: begin
                if (depth_reg == DW'(NODES + 1)) begin
                    depth_next = '0;
                    if (item_reg.op == wuf_pkg::OP_QUERY) begin
                        mo_next.known      = 1'b1;
                        mo_next.difference = pa_reg - pot_rdata;
                        mv_next            = 1'b1;
                    end else begin
                        par_we    = 1'b1;
                        par_waddr = ra_reg;
                        par_wdata = cur_reg;
                        pot_we    = 1'b1;
                        pot_waddr = ra_reg;
                        pot_wdata = pot_rdata - pa_reg +
                            {{(PW-wuf_pkg::OFF_W){item_reg.offset[wuf_pkg::OFF_W-1]}},
                             item_reg.offset};
                    end
                end else begin
                    mv_next = 1'b1;
                end
                state_next = wuf_pkg::ST_IDLE;
            end
            default: begin
                state_next = wuf_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = mv_reg;
    assign m_data  = mo_reg;

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wuf_pkg::ST_CLEAR |-> !s_ready && !mv_reg)
        else $error("input taken during clear");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !m_ready |=> mv_reg && $stable(mo_reg))
        else $error("result lost under stall");
    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !mo_reg.known |-> mo_reg.difference == '0)
        else $error("unknown result carries a difference");

endmodule
`default_nettype wire

// ===== verif/wuf_checker.sv =====
`default_nettype none
module wuf_checker #(
    parameter int NODES = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire wuf_pkg::in_beat_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire wuf_pkg::out_beat_t m_data,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = wuf_pkg::NODE_W;
    localparam int PW = wuf_pkg::POT_W;
    localparam int OW = wuf_pkg::OFF_W;

    logic [NW-1:0]      link_of [NODES];
    logic [PW-1:0]      pot_of [NODES];
    wuf_pkg::out_beat_t answers_due [$];

    function automatic logic [NW-1:0] root_of(input logic [NW-1:0] n);
        logic [NW-1:0] trail [$];
        logic [NW-1:0] cur;
        logic [NW-1:0] x;
        cur = n;
        while (link_of[cur] != cur) begin
            trail.push_back(cur);
            cur = link_of[cur];
        end
        while (trail.size() > 0) begin
            x = trail.pop_back();
            pot_of[x] = pot_of[x] + pot_of[link_of[x]];
            link_of[x] = cur;
        end
        return cur;
    endfunction

    task automatic apply_beat(input wuf_pkg::in_beat_t b);
        logic [NW-1:0]      ra;
        logic [NW-1:0]      rb;
        logic [PW-1:0]      off;
        wuf_pkg::out_beat_t ans;
        bit                 ok;
        ok = (int'(b.node_a) < NODES) && (int'(b.node_b) < NODES);
        off = {{(PW-OW){b.offset[OW-1]}}, b.offset};
        if (b.op == wuf_pkg::OP_MERGE) begin
            if (ok) begin
                ra = root_of(b.node_a);
                rb = root_of(b.node_b);
                if (ra != rb) begin
                    link_of[ra] = rb;
                    pot_of[ra] = pot_of[b.node_b] - pot_of[b.node_a] + off;
                end
            end
        end else begin
            ans = '0;
            if (ok) begin
                ra = root_of(b.node_a);
                rb = root_of(b.node_b);
                if (ra == rb) begin
                    ans.known = 1'b1;
                    ans.difference = pot_of[b.node_a] - pot_of[b.node_b];
                end
            end
            answers_due.push_back(ans);
        end
    endtask

    always @(posedge aclk) begin
        wuf_pkg::out_beat_t want;
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                link_of[i] = i[NW-1:0];
                pot_of[i] = '0;
            end
            answers_due.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result beat known=%0b difference=%0d",
                           m_data.known, m_data.difference);
                    fail_count = fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (m_data.known !== want.known) begin
                        $error("known: expected %0b, got %0b", want.known, m_data.known);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.difference !== want.difference) begin
                        $error("difference: expected %0d, got %0d",
                               want.difference, m_data.difference);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                apply_beat(s_data);
        end
        pending = answers_due.size();
    end
endmodule
`default_nettype wire

// ===== verif/tb_weighted_union_find_top.sv =====
`default_nettype none
module tb_weighted_union_find_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 1024;
    localparam int STALL_LIMIT = 100000;
    localparam int NW = wuf_pkg::NODE_W;
    localparam int OW = wuf_pkg::OFF_W;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    wuf_pkg::in_beat_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    wuf_pkg::out_beat_t m_data;
    int        fail_count;
    int        pending;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_off = 1'b0;
    int        quiet_cycles = 0;
    logic [NW-1:0] span = 10'd15;

    always #5 aclk = ~aclk;

    weighted_union_find_top #(.NODES(NODES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    wuf_checker #(.NODES(NODES)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(input logic op, input logic [NW-1:0] a,
                        input logic [NW-1:0] b, input logic [OW-1:0] off);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{op: op, node_a: a, node_b: b, offset: off};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    function automatic logic [NW-1:0] pick_node();
        if ($urandom_range(9) == 0)
            return NW'($urandom());
        return NW'($urandom_range(int'(span)));
    endfunction

    task automatic random_items(input int count);
        logic [OW-1:0] off;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: off = $urandom();
                1: off = {1'b1, 31'($urandom_range(3))};
                2: off = {1'b0, {31{1'b1}}} - OW'($urandom_range(3));
                default: off = OW'($urandom_range(20));
            endcase
            send(($urandom_range(99) < 55) ? wuf_pkg::OP_QUERY : wuf_pkg::OP_MERGE,
                 pick_node(), pick_node(), off);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(wuf_pkg::OP_QUERY, 10'd0, 10'd0, '0);
        send(wuf_pkg::OP_QUERY, 10'd0, 10'd1023, '1);
        send(wuf_pkg::OP_MERGE, 10'd0, 10'd1023, 32'h8000_0000);
        send(wuf_pkg::OP_QUERY, 10'd0, 10'd1023, '0);
        send(wuf_pkg::OP_QUERY, 10'd1023, 10'd0, '0);
        send(wuf_pkg::OP_MERGE, 10'd1023, 10'd0, 32'h7fff_ffff);
        send(wuf_pkg::OP_MERGE, 10'd5, 10'd5, 32'd9);
        send(wuf_pkg::OP_QUERY, 10'd5, 10'd5, '0);
        send(wuf_pkg::OP_MERGE, 10'd1, 10'd0, 32'h7fff_ffff);
        send(wuf_pkg::OP_MERGE, 10'd2, 10'd1, 32'h7fff_ffff);
        send(wuf_pkg::OP_MERGE, 10'd3, 10'd2, 32'h7fff_ffff);
        send(wuf_pkg::OP_MERGE, 10'd4, 10'd3, 32'h7fff_ffff);
        send(wuf_pkg::OP_QUERY, 10'd4, 10'd1023, '0);
        send(wuf_pkg::OP_MERGE, 10'd682, 10'd341, 32'h5555_5555);
        send(wuf_pkg::OP_MERGE, 10'd341, 10'd4, 32'haaaa_aaaa);
        send(wuf_pkg::OP_QUERY, 10'd682, 10'd0, '0);
        send(wuf_pkg::OP_QUERY, 10'd682, 10'd6, '0);
        for (int i = 0; i < 4; i++)
            send(wuf_pkg::OP_MERGE, 10'd0, 10'd0, 32'h8000_0000);

        send_idle_pct = 0;  recv_stall_pct = 0;  span = 10'd15;
        random_items(300);
        send_idle_pct = 72; recv_stall_pct = 0;  span = 10'd63;
        random_items(250);
        send_idle_pct = 0;  recv_stall_pct = 72; span = 10'd31;
        random_items(250);
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_items(60);
        join
        send_idle_pct = 35; recv_stall_pct = 35; span = 10'd255;
        random_items(250);
        send_idle_pct = 0;  recv_stall_pct = 0;  span = 10'd1023;
        random_items(290);
        s_valid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
